/* src/hsfd_pkg.sv */
// Shared constants and the CRC-8 byte update for the humidity sensor frame decoder.
// No dependencies; compiled first.
`default_nettype none

package hsfd_pkg;

  // CRC-8 over each word: polynomial x^8+x^5+x^4+1, preset all ones, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within a frame; idle once a frame has been delivered
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_CRC1  = 3'd2;
  localparam logic [2:0] POS_WORD2 = 3'd3;
  localparam logic [2:0] POS_HI2   = 3'd3;
  localparam logic [2:0] POS_CRC2  = 3'd5;
  localparam logic [2:0] POS_IDLE  = 3'd7;

  // Frame lengths in bytes
  localparam logic [2:0] LEN_MEAS   = 3'd6;
  localparam logic [2:0] LEN_STATUS = 3'd3;

  // Conversion: floor(SPAN * raw / 65535), temperature then offset
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_KIND = 2'd0;
  localparam logic [1:0] REG_TEMP_HIGH  = 2'd1;
  localparam logic [1:0] REG_HUM_HIGH   = 2'd2;
  localparam logic [1:0] REG_HUM_LOW    = 2'd3;

  // Configuration reset values
  localparam logic signed [14:0] TEMP_HIGH_RST = 15'sd4000;
  localparam logic [13:0]        HUM_HIGH_RST  = 14'd8000;
  localparam logic [13:0]        HUM_LOW_RST   = 14'd2000;

  // One byte through the CRC register, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/hsfd_ifs.sv */
// Channel interfaces of the frame decoder: received bytes, decoded results, register writes.
// No dependencies; compiled after hsfd_pkg.
`default_nettype none

// Received sensor bytes
interface hsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

// Decoded frame results
interface hsfd_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        status_word;
  logic               frame_valid;
  logic               temp_alert;
  logic               hum_high_alert;
  logic               hum_low_alert;

  modport source (output valid, temperature_centi, humidity_centi, status_word, frame_valid,
                  temp_alert, hum_high_alert, hum_low_alert, input ready);
  modport sink   (input valid, temperature_centi, humidity_centi, status_word, frame_valid,
                  temp_alert, hum_high_alert, hum_low_alert, output ready);
endinterface

// Register write requests
interface hsfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [14:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

/* src/humidity_sensor_frame_decoder_core.sv */
// Humidity sensor frame decoder: CRC check, conversion to hundredths and alert flags.
// A frame's result is registered in stage 1, stage 2 and the stage 3 result register.
// Takes one byte per cycle when not stalled; CRC and frame assembly are combinational.
// A waiting result stalls intake only once all three pipeline stages are full.
// Reset (rst, synchronous): limits to defaults, measurement mode, frame position 0.
// Depends on hsfd_pkg and the interfaces in hsfd_ifs.sv.
`default_nettype none

module humidity_sensor_frame_decoder_core
  import hsfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  hsfd_byte_if.sink      frame_data,
  hsfd_result_if.source  result,
  hsfd_cfg_if.sink       cfg
);

  // Configuration registers
  logic               frame_kind;
  logic signed [14:0] temp_high_limit;
  logic [13:0]        hum_high_limit;
  logic [13:0]        hum_low_limit;

  // Frame assembly state
  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic        crc_good;

  // Pipeline registers
  logic        s1_valid, s1_kind, s1_good;
  logic [15:0] s1_w1, s1_w2;
  logic        s2_valid, s2_kind, s2_good;
  logic [15:0] s2_status;
  logic [30:0] s2_tprod;
  logic [29:0] s2_hprod;

  // Output registers
  logic               out_valid;
  logic signed [14:0] out_temp;
  logic [13:0]        out_hum;
  logic [15:0]        out_status;
  logic               out_frame_valid, out_temp_alert, out_hum_high, out_hum_low;

  // Handshake
  logic s1_ready, s2_ready, s3_ready, accept;

  assign s3_ready = !out_valid || result.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign frame_data.ready = s1_ready;
  assign accept = frame_data.valid && s1_ready;
  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind      <= 1'b0;
      temp_high_limit <= TEMP_HIGH_RST;
      hum_high_limit  <= HUM_HIGH_RST;
      hum_low_limit   <= HUM_LOW_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_FRAME_KIND: frame_kind      <= cfg.wdata[0];
        REG_TEMP_HIGH:  temp_high_limit <= $signed(cfg.wdata);
        REG_HUM_HIGH:   hum_high_limit  <= cfg.wdata[13:0];
        REG_HUM_LOW:    hum_low_limit   <= cfg.wdata[13:0];
        default: ;
      endcase
    end
  end

  // Frame assembly: position, CRC and word capture for the byte on offer
  logic [2:0]  frame_len, pos_eff;
  logic [7:0]  crc_eff, crc_calc;
  logic        good_eff, active, is_crc_pos, is_hi, last_byte;
  logic [2:0]  byte_position_next;
  logic [7:0]  running_crc_next;
  logic [15:0] first_word_next, second_word_next;
  logic        crc_good_next;

  always_comb begin
    frame_len  = frame_kind ? LEN_STATUS : LEN_MEAS;
    pos_eff    = frame_data.frame_start ? POS_FIRST : byte_position;
    crc_eff    = frame_data.frame_start ? CRC_INIT : running_crc;
    good_eff   = frame_data.frame_start || crc_good;
    active     = pos_eff < frame_len;
    is_crc_pos = (pos_eff == POS_CRC1) || (pos_eff == POS_CRC2);
    is_hi      = (pos_eff == POS_FIRST) || (pos_eff == POS_HI2);
    last_byte  = active && (pos_eff == frame_len - 3'd1);
    crc_calc   = crc8_byte(crc_eff, frame_data.data_byte);

    byte_position_next = last_byte ? POS_IDLE : pos_eff + 3'd1;
    first_word_next    = first_word;
    second_word_next   = second_word;
    if (is_crc_pos) begin
      running_crc_next = CRC_INIT;
      crc_good_next    = good_eff && (crc_eff == frame_data.data_byte);
    end else begin
      running_crc_next = crc_calc;
      crc_good_next    = good_eff;
      if (pos_eff < POS_WORD2) begin
        if (is_hi) first_word_next = {frame_data.data_byte, first_word[7:0]};
        else       first_word_next = {first_word[15:8], frame_data.data_byte};
      end else begin
        if (is_hi) second_word_next = {frame_data.data_byte, second_word[7:0]};
        else       second_word_next = {second_word[15:8], frame_data.data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
      running_crc   <= CRC_INIT;
      first_word    <= '0;
      second_word   <= '0;
      crc_good      <= 1'b1;
    end else if (accept && active) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      first_word    <= first_word_next;
      second_word   <= second_word_next;
      crc_good      <= crc_good_next;
    end
  end

  // Stage 1: completed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_kind <= frame_kind;
      s1_good <= crc_good_next;
      s1_w1   <= first_word_next;
      s1_w2   <= second_word_next;
    end
  end

  // Stage 2: scale the raw words
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_kind   <= s1_kind;
      s2_good   <= s1_good;
      s2_status <= s1_w1;
      s2_tprod  <= 31'(s1_w1) * 31'(TEMP_SPAN);
      s2_hprod  <= 30'(s1_w2) * 30'(HUM_SPAN);
    end
  end

  // Divide by 65535: estimate x>>16, remainder is low half plus estimate, one correction
  logic [14:0]        t_q0, t_q;
  logic [16:0]        t_r0;
  logic [13:0]        h_q0, h_q;
  logic [16:0]        h_r0;
  logic signed [15:0] t_centi;
  logic signed [14:0] temp_val;
  logic [13:0]        hum_val;
  logic               meas_ok;

  always_comb begin
    t_q0     = s2_tprod[30:16];
    t_r0     = 17'(s2_tprod[15:0]) + 17'(t_q0);
    t_q      = t_q0 + 15'(t_r0 >= FULL_SCALE);
    h_q0     = s2_hprod[29:16];
    h_r0     = 17'(s2_hprod[15:0]) + 17'(h_q0);
    h_q      = h_q0 + 14'(h_r0 >= FULL_SCALE);
    t_centi  = $signed({1'b0, t_q}) - TEMP_OFFSET;
    temp_val = s2_kind ? '0 : t_centi[14:0];
    hum_val  = s2_kind ? '0 : h_q;
    meas_ok  = s2_good && !s2_kind;
  end

  // Stage 3: result register with alerts
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_temp        <= temp_val;
      out_hum         <= hum_val;
      out_status      <= s2_kind ? s2_status : '0;
      out_frame_valid <= s2_good;
      out_temp_alert  <= meas_ok && (temp_val > temp_high_limit);
      out_hum_high    <= meas_ok && (hum_val > hum_high_limit);
      out_hum_low     <= meas_ok && (hum_val < hum_low_limit);
    end
  end

  assign result.valid             = out_valid;
  assign result.temperature_centi = out_temp;
  assign result.humidity_centi    = out_hum;
  assign result.status_word       = out_status;
  assign result.frame_valid       = out_frame_valid;
  assign result.temp_alert        = out_temp_alert;
  assign result.hum_high_alert    = out_hum_high;
  assign result.hum_low_alert     = out_hum_low;

endmodule

`default_nettype wire
